@@ hw/rtl/tst_pkg.sv @@
package tst_pkg;

	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int CRN_W = 3 * IDX_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam int DEF_MAX_TRIANGLES = 1024;
	localparam int DEF_MAX_VERTICES  = 1024;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRI_RD,
		ST_TRI_CHK,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_MARK_RD,
		ST_MARK_CAP,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [IDX_W-1:0] triangle;
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
	} req_t;

	typedef struct packed {
		logic changed;
		logic tri_is_selected;
		logic first_vertex_marked;
		logic second_vertex_marked;
		logic third_vertex_marked;
	} rsp_t;

endpackage

@@ hw/rtl/triangle_selection_tracker.sv @@
// Triangle selection tracker: one request at a time through a small sequencer around
// triangle, corner and vertex-count memories (one write and one registered read each).
// Steps: read the triangle bit and corners; on an add or remove that flips the bit, read
// and write the count of each in-range corner; read the three corner marks; respond.
// A clear sweeps max(triangles, vertices) entries. Requests are taken only when idle;
// req_stall is high otherwise. Reset: the same clearing pass zeroes the selection stores.
module triangle_selection_tracker #(
	parameter int MAX_TRIANGLES = tst_pkg::DEF_MAX_TRIANGLES,
	parameter int MAX_VERTICES  = tst_pkg::DEF_MAX_VERTICES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tst_pkg::rsp_t rsp
);

	localparam int IDX_W = tst_pkg::IDX_W;
	localparam int CNT_W = tst_pkg::CNT_W;
	localparam int IDX_SPAN = 1 << IDX_W;
	localparam int TRI_DEPTH = (MAX_TRIANGLES < IDX_SPAN) ? MAX_TRIANGLES : IDX_SPAN;
	localparam int VTX_DEPTH = (MAX_VERTICES < IDX_SPAN) ? MAX_VERTICES : IDX_SPAN;
	localparam int TRI_AW = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
	localparam int VTX_AW = $clog2(VTX_DEPTH);
	localparam int SWP_DEPTH = (TRI_DEPTH > VTX_DEPTH) ? TRI_DEPTH : VTX_DEPTH;
	localparam int SWP_W = $clog2(SWP_DEPTH);
	localparam int TP_W = $clog2(TRI_DEPTH + 1);
	localparam int VP_W = $clog2(VTX_DEPTH + 1);
	localparam logic [SWP_W-1:0] SWP_LAST = SWP_W'(SWP_DEPTH - 1);

	tst_pkg::state_t state_q, state_nxt;

	// control
	logic [1:0]       k_q;
	logic [SWP_W-1:0] sweep_q;
	logic             pend_q;
	logic [TP_W-1:0]  tpop_q;
	logic [VP_W-1:0]  vpop_q;

	// request context
	tst_pkg::op_t     op_q;
	logic [IDX_W-1:0] tri_q;
	logic [IDX_W-1:0] crn_q [3];
	logic             changed_q;
	logic             sel_q;
	logic [2:0]       mark_q;

	// memories and registered read data
	logic                      tri_mem [TRI_DEPTH];
	logic [tst_pkg::CRN_W-1:0] crn_mem [TRI_DEPTH];
	logic [CNT_W-1:0]          vtx_mem [VTX_DEPTH];
	logic                      tbit_rd_q;
	logic [tst_pkg::CRN_W-1:0] crn_rd_q;
	logic [CNT_W-1:0]          vcnt_rd_q;

	logic              accept;
	logic              in_tri_ok;
	logic [IDX_W-1:0]  cur_v;
	logic              vok;
	logic              do_upd;
	logic [1:0]        k_nxt;
	logic [CNT_W-1:0]  cnt_new;
	logic              out_ld;
	logic              tri_we;
	logic [TRI_AW-1:0] tri_wa;
	logic              tri_wd;
	logic              vtx_we;
	logic [VTX_AW-1:0] vtx_wa;
	logic [CNT_W-1:0]  vtx_wd;
	logic              crn_we;
	logic              swp_tri_ok;
	logic              swp_vtx_ok;

	assign accept    = req_valid && !req_stall;
	assign in_tri_ok = 32'(req.triangle) < 32'(MAX_TRIANGLES);
	assign k_nxt     = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
	assign swp_tri_ok = 32'(sweep_q) < 32'(TRI_DEPTH);
	assign swp_vtx_ok = 32'(sweep_q) < 32'(VTX_DEPTH);

	always_comb begin
		unique case (k_q)
			2'd0:    cur_v = crn_q[0];
			2'd1:    cur_v = crn_q[1];
			default: cur_v = crn_q[2];
		endcase
	end

	assign vok = 32'(cur_v) < 32'(MAX_VERTICES);
	assign do_upd = (op_q == tst_pkg::OP_ADD && !tbit_rd_q) ||
		(op_q == tst_pkg::OP_REMOVE && tbit_rd_q);

	// saturating count step
	always_comb begin
		if (op_q == tst_pkg::OP_ADD) begin
			cnt_new = (vcnt_rd_q == tst_pkg::CNT_MAX) ? vcnt_rd_q : vcnt_rd_q + CNT_W'(1);
		end else begin
			cnt_new = (vcnt_rd_q == '0) ? vcnt_rd_q : vcnt_rd_q - CNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tst_pkg::ST_IDLE: begin
				if (accept) begin
					if (tst_pkg::op_t'(req.operation) == tst_pkg::OP_CLEAR)
						state_nxt = tst_pkg::ST_SWEEP;
					else if (!in_tri_ok)
						state_nxt = tst_pkg::ST_DONE;
					else
						state_nxt = tst_pkg::ST_TRI_RD;
				end
			end
			tst_pkg::ST_TRI_RD: state_nxt = tst_pkg::ST_TRI_CHK;
			tst_pkg::ST_TRI_CHK: begin
				if (op_q != tst_pkg::OP_LOAD && do_upd)
					state_nxt = tst_pkg::ST_UPD_RD;
				else
					state_nxt = tst_pkg::ST_MARK_RD;
			end
			tst_pkg::ST_UPD_RD: begin
				if (vok)
					state_nxt = tst_pkg::ST_UPD_WR;
				else if (k_q == 2'd2)
					state_nxt = tst_pkg::ST_MARK_RD;
			end
			tst_pkg::ST_UPD_WR: begin
				state_nxt = (k_q == 2'd2) ? tst_pkg::ST_MARK_RD : tst_pkg::ST_UPD_RD;
			end
			tst_pkg::ST_MARK_RD: state_nxt = tst_pkg::ST_MARK_CAP;
			tst_pkg::ST_MARK_CAP: begin
				if (k_q == 2'd2)
					state_nxt = tst_pkg::ST_DONE;
				else
					state_nxt = tst_pkg::ST_MARK_RD;
			end
			tst_pkg::ST_SWEEP: begin
				if (sweep_q == SWP_LAST)
					state_nxt = pend_q ? tst_pkg::ST_DONE : tst_pkg::ST_IDLE;
			end
			tst_pkg::ST_DONE: begin
				if (out_ld)
					state_nxt = tst_pkg::ST_IDLE;
			end
			default: state_nxt = tst_pkg::ST_IDLE;
		endcase
	end

	// per-state strobes
	always_comb begin
		req_stall = 1'b1;
		out_ld    = 1'b0;
		tri_we    = 1'b0;
		tri_wa    = tri_q[TRI_AW-1:0];
		tri_wd    = 1'b0;
		vtx_we    = 1'b0;
		vtx_wa    = cur_v[VTX_AW-1:0];
		vtx_wd    = cnt_new;
		crn_we    = 1'b0;
		unique case (state_q)
			tst_pkg::ST_IDLE: req_stall = 1'b0;
			tst_pkg::ST_TRI_RD: crn_we = (op_q == tst_pkg::OP_LOAD);
			tst_pkg::ST_TRI_CHK: begin
				tri_we = (op_q != tst_pkg::OP_LOAD) && do_upd;
				tri_wd = !tbit_rd_q;
			end
			tst_pkg::ST_UPD_WR: vtx_we = 1'b1;
			tst_pkg::ST_SWEEP: begin
				tri_we = swp_tri_ok;
				tri_wa = sweep_q[TRI_AW-1:0];
				tri_wd = 1'b0;
				vtx_we = swp_vtx_ok;
				vtx_wa = sweep_q[VTX_AW-1:0];
				vtx_wd = '0;
			end
			tst_pkg::ST_DONE: out_ld = !rsp_valid || !rsp_stall;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (tri_we)
			tri_mem[tri_wa] <= tri_wd;
		tbit_rd_q <= tri_mem[tri_q[TRI_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (crn_we)
			crn_mem[tri_q[TRI_AW-1:0]] <= {crn_q[2], crn_q[1], crn_q[0]};
		crn_rd_q <= crn_mem[tri_q[TRI_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vtx_we)
			vtx_mem[vtx_wa] <= vtx_wd;
		vcnt_rd_q <= vtx_mem[cur_v[VTX_AW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tst_pkg::ST_SWEEP;
			k_q       <= '0;
			sweep_q   <= '0;
			pend_q    <= 1'b0;
			tpop_q    <= '0;
			vpop_q    <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_ld)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
			unique case (state_q)
				tst_pkg::ST_IDLE: begin
					if (accept && tst_pkg::op_t'(req.operation) == tst_pkg::OP_CLEAR) begin
						sweep_q <= '0;
						pend_q  <= 1'b1;
						tpop_q  <= '0;
						vpop_q  <= '0;
					end
				end
				tst_pkg::ST_TRI_CHK: begin
					k_q <= '0;
					if (op_q != tst_pkg::OP_LOAD && do_upd) begin
						if (op_q == tst_pkg::OP_ADD)
							tpop_q <= tpop_q + TP_W'(1);
						else
							tpop_q <= tpop_q - TP_W'(1);
					end
				end
				tst_pkg::ST_UPD_RD: begin
					if (!vok)
						k_q <= k_nxt;
				end
				tst_pkg::ST_UPD_WR: begin
					k_q <= k_nxt;
					// a vertex mark flips exactly when its count leaves or reaches zero
					if (op_q == tst_pkg::OP_ADD && vcnt_rd_q == '0)
						vpop_q <= vpop_q + VP_W'(1);
					else if (op_q == tst_pkg::OP_REMOVE && vcnt_rd_q == CNT_W'(1))
						vpop_q <= vpop_q - VP_W'(1);
				end
				tst_pkg::ST_MARK_CAP: k_q <= k_nxt;
				tst_pkg::ST_SWEEP: sweep_q <= sweep_q + SWP_W'(1);
				default: ;
			endcase
		end
	end

	// request context and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			tst_pkg::ST_IDLE: begin
				if (accept) begin
					op_q      <= tst_pkg::op_t'(req.operation);
					tri_q     <= req.triangle;
					crn_q[0]  <= req.corner_a;
					crn_q[1]  <= req.corner_b;
					crn_q[2]  <= req.corner_c;
					changed_q <= (tst_pkg::op_t'(req.operation) == tst_pkg::OP_CLEAR) &&
						(tpop_q != '0 || vpop_q != '0);
					sel_q     <= 1'b0;
					mark_q    <= '0;
				end
			end
			tst_pkg::ST_TRI_CHK: begin
				if (op_q == tst_pkg::OP_LOAD) begin
					sel_q <= tbit_rd_q;
				end else begin
					sel_q    <= do_upd ? !tbit_rd_q : tbit_rd_q;
					crn_q[0] <= crn_rd_q[IDX_W-1:0];
					crn_q[1] <= crn_rd_q[2*IDX_W-1:IDX_W];
					crn_q[2] <= crn_rd_q[3*IDX_W-1:2*IDX_W];
					if (do_upd)
						changed_q <= 1'b1;
				end
			end
			tst_pkg::ST_MARK_CAP: mark_q[k_q] <= vok && (vcnt_rd_q != '0);
			tst_pkg::ST_DONE: begin
				if (out_ld) begin
					rsp.changed              <= changed_q;
					rsp.tri_is_selected      <= sel_q;
					rsp.first_vertex_marked  <= mark_q[0];
					rsp.second_vertex_marked <= mark_q[1];
					rsp.third_vertex_marked  <= mark_q[2];
				end
			end
			default: ;
		endcase
	end

endmodule

@@ tb/tb_triangle_selection_tracker.sv @@
module tb_triangle_selection_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TRI     = tst_pkg::DEF_MAX_TRIANGLES;
	localparam int NUM_VTX     = tst_pkg::DEF_MAX_VERTICES;
	localparam int HOLD_CYCLES = 300;
	localparam int SHARED_TRIS = 40;
	localparam int SHARED_VTX  = 777;
	localparam int RAND_CHUNK  = 90;

	class selection_scoreboard;
		logic [2:0][tst_pkg::IDX_W-1:0] corner_set [NUM_TRI];
		bit                             tri_selected [NUM_TRI];
		logic [tst_pkg::CNT_W-1:0]      vtx_count [NUM_VTX];
		bit                             vtx_marked [NUM_VTX];
		tst_pkg::rsp_t                  expected_rsp [$];
		int                             failures;

		function new();
			for (int i = 0; i < NUM_TRI; i++) begin
				corner_set[i] = '0;
			end
			for (int i = 0; i < NUM_VTX; i++) begin
				vtx_count[i] = '0;
			end
			failures = 0;
		endfunction

		function bit mark_of(logic [tst_pkg::IDX_W-1:0] v);
			if (int'(v) >= NUM_VTX) return 1'b0;
			return vtx_marked[v];
		endfunction

		function void add_expected(tst_pkg::rsp_t e);
			expected_rsp.insert(expected_rsp.size(), e);
		endfunction

		// predict the response of one accepted request and update the selection state
		function void note_request(tst_pkg::req_t r);
			tst_pkg::rsp_t             exp;
			int                        t;
			logic [tst_pkg::IDX_W-1:0] v;
			exp = '0;
			t = int'(r.triangle);
			if (tst_pkg::op_t'(r.operation) == tst_pkg::OP_CLEAR) begin
				for (int i = 0; i < NUM_TRI; i++) begin
					if (tri_selected[i]) exp.changed = 1'b1;
					tri_selected[i] = 1'b0;
				end
				for (int i = 0; i < NUM_VTX; i++) begin
					if (vtx_marked[i]) exp.changed = 1'b1;
					vtx_marked[i] = 1'b0;
					vtx_count[i] = '0;
				end
				add_expected(exp);
				return;
			end
			if (t >= NUM_TRI) begin
				add_expected(exp);
				return;
			end
			case (tst_pkg::op_t'(r.operation))
				tst_pkg::OP_LOAD: begin
					corner_set[t] = {r.corner_c, r.corner_b, r.corner_a};
				end
				tst_pkg::OP_ADD: begin
					if (!tri_selected[t]) begin
						tri_selected[t] = 1'b1;
						exp.changed = 1'b1;
						for (int k = 0; k < 3; k++) begin
							v = corner_set[t][k];
							if (int'(v) < NUM_VTX) begin
								if (vtx_count[v] != tst_pkg::CNT_MAX) vtx_count[v]++;
								vtx_marked[v] = 1'b1;
							end
						end
					end
				end
				tst_pkg::OP_REMOVE: begin
					if (tri_selected[t]) begin
						tri_selected[t] = 1'b0;
						exp.changed = 1'b1;
						// counts stick at zero; a corner loaded after the add may already be there
						for (int k = 0; k < 3; k++) begin
							v = corner_set[t][k];
							if (int'(v) < NUM_VTX) begin
								if (vtx_count[v] != '0) vtx_count[v]--;
								if (vtx_count[v] == '0) vtx_marked[v] = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
			exp.tri_is_selected      = tri_selected[t];
			exp.first_vertex_marked  = mark_of(corner_set[t][0]);
			exp.second_vertex_marked = mark_of(corner_set[t][1]);
			exp.third_vertex_marked  = mark_of(corner_set[t][2]);
			add_expected(exp);
		endfunction

		function void check_response(tst_pkg::rsp_t got);
			tst_pkg::rsp_t exp;
			bit            bad;
			if (expected_rsp.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response %b at %0t", got, $realtime);
				return;
			end
			exp = expected_rsp.pop_front();
			bad = (got.changed !== exp.changed)
				|| (got.tri_is_selected !== exp.tri_is_selected)
				|| (got.first_vertex_marked !== exp.first_vertex_marked)
				|| (got.second_vertex_marked !== exp.second_vertex_marked)
				|| (got.third_vertex_marked !== exp.third_vertex_marked);
			if (bad) begin
				failures++;
				if (failures <= 10)
					$display("response mismatch at %0t: expected %b got %b (chg,tri,v0,v1,v2)",
						$realtime, exp, got);
			end
		endfunction

		function int outstanding();
			return expected_rsp.size();
		endfunction
	endclass

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	tst_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	tst_pkg::rsp_t rsp;

	selection_scoreboard sb = new();
	bit loaded [NUM_TRI];
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_gen  = 0;
	int hold_taken = 0;
	int hold_left  = 0;

	triangle_selection_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// response side back-pressure, with one long hold-off
	always @(negedge clk) begin
		if (hold_taken != hold_gen) begin
			hold_taken = hold_gen;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);
	end

	// called and returns at a falling edge
	task automatic send_request(input tst_pkg::req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic issue(input tst_pkg::op_t op, input int t, input int a, input int b,
		input int c);
		tst_pkg::req_t r;
		r.operation = op;
		r.triangle  = t[tst_pkg::IDX_W-1:0];
		r.corner_a  = a[tst_pkg::IDX_W-1:0];
		r.corner_b  = b[tst_pkg::IDX_W-1:0];
		r.corner_c  = c[tst_pkg::IDX_W-1:0];
		if (op == tst_pkg::OP_LOAD) loaded[t] = 1'b1;
		send_request(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly a small working set so counts and shared corners interact
	function automatic int pick_triangle();
		if ($urandom_range(3) != 0) return $urandom_range(31);
		return $urandom_range(NUM_TRI - 1);
	endfunction

	function automatic int pick_vertex();
		if ($urandom_range(3) != 0) return $urandom_range(15);
		return $urandom_range(NUM_VTX - 1);
	endfunction

	task automatic random_items(input int n);
		int t;
		int pick;
		for (int i = 0; i < n; i++) begin
			t = pick_triangle();
			pick = $urandom_range(99);
			if (pick < 2)
				issue(tst_pkg::OP_CLEAR, $urandom_range(NUM_TRI - 1), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023));
			else if (!loaded[t] || pick < 22)
				issue(tst_pkg::OP_LOAD, t, pick_vertex(), pick_vertex(), pick_vertex());
			else if (pick < 61)
				issue(tst_pkg::OP_ADD, t, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023));
			else
				issue(tst_pkg::OP_REMOVE, t, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023));
		end
	endtask

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests
		issue(tst_pkg::OP_CLEAR, 1023, 1023, 1023, 1023);
		issue(tst_pkg::OP_LOAD, 0, 0, 1, 2);
		issue(tst_pkg::OP_ADD, 0, 0, 0, 0);
		issue(tst_pkg::OP_ADD, 0, 0, 0, 0);
		issue(tst_pkg::OP_LOAD, 1023, 1023, 1023, 1023);
		issue(tst_pkg::OP_ADD, 1023, 0, 0, 0);
		issue(tst_pkg::OP_LOAD, 1, 2, 3, 1023);
		issue(tst_pkg::OP_ADD, 1, 0, 0, 0);
		issue(tst_pkg::OP_REMOVE, 0, 0, 0, 0);
		issue(tst_pkg::OP_REMOVE, 0, 0, 0, 0);
		// reload while selected, then remove: counts of the new corners are already zero
		issue(tst_pkg::OP_LOAD, 1, 5, 6, 7);
		issue(tst_pkg::OP_REMOVE, 1, 0, 0, 0);
		issue(tst_pkg::OP_REMOVE, 1023, 1023, 1023, 1023);
		issue(tst_pkg::OP_ADD, 1, 0, 0, 0);
		issue(tst_pkg::OP_CLEAR, 0, 0, 0, 0);
		issue(tst_pkg::OP_CLEAR, 0, 0, 0, 0);
		// corners survive a clear
		issue(tst_pkg::OP_ADD, 1023, 0, 0, 0);
		issue(tst_pkg::OP_LOAD, 512, 'h155, 'h2aa, 'h3ff);
		issue(tst_pkg::OP_ADD, 512, 0, 0, 0);
		issue(tst_pkg::OP_REMOVE, 512, 0, 0, 0);
		issue(tst_pkg::OP_CLEAR, 'h2aa, 'h155, 'h2aa, 'h155);

		// pile many triangles onto one vertex, then take them all off again
		for (int t = 0; t < SHARED_TRIS; t++) begin
			issue(tst_pkg::OP_LOAD, t, SHARED_VTX, SHARED_VTX, SHARED_VTX);
			issue(tst_pkg::OP_ADD, t, 0, 0, 0);
		end
		for (int t = 0; t < SHARED_TRIS; t++) begin
			issue(tst_pkg::OP_REMOVE, t, $urandom_range(1023), $urandom_range(1023),
				$urandom_range(1023));
		end

		// random traffic, one chunk per idling mode
		hold_gen++;
		random_items(RAND_CHUNK);
		idle_pct  = 68;
		stall_pct = 0;
		random_items(RAND_CHUNK);
		wait_drained();
		idle_pct  = 0;
		stall_pct = 68;
		random_items(RAND_CHUNK);
		idle_pct  = 14;
		stall_pct = 14;
		random_items(RAND_CHUNK);

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tst_pkg.sv
hw/rtl/triangle_selection_tracker.sv
tb/tb_triangle_selection_tracker.sv
